// ===== sv/pvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pvm_pkg;

	// default configuration of the block
	localparam int PVM_MAX_CLASSES    = 7;
	localparam int PVM_INTENSITY_BITS = 16;

	// fixed field widths
	localparam int CENTER_W   = 16;
	localparam int COUNT_W    = 3;
	localparam int CLASS_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int QW         = 17;
	localparam logic [QW-1:0] Q_ONE = 17'h10000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 3'd0;
	localparam int                   CFG_CENTER_BASE = 1;

	// how the weights of one result are formed at the end of the chain
	typedef enum logic [1:0] {
		PVM_FULL_LOW,
		PVM_FULL_UP,
		PVM_DIVIDE,
		PVM_NONE
	} pvm_mode_t;

	// control word that travels with each transaction
	typedef struct packed {
		logic                 valid;
		pvm_mode_t            mode;
		logic [CLASS_W-1:0]   lower;
		logic                 last;
	} pvm_ctl_t;

endpackage

`default_nettype wire

// ===== sv/partial_volume_membership.sv =====
`timescale 1ns / 1ps
`default_nettype none

// partial-volume membership of one voxel intensity between two neighboring
// class centers. a transaction is taken at every clock edge where start is
// high; busy stays low, so a new voxel can be issued every cycle and the
// block sustains one voxel per clock. each voxel gives exactly one result,
// shown for one cycle with done high, in issue order, after the voxel has
// passed two classification stages (compare against all centers, then
// interval pick and operand subtraction), a chain of 17 division cells that
// each resolve one quotient bit of the Q16 weight, and one output register.
// the receiver cannot stall, so it must take every result in the cycle it
// appears. centers and class_count are written through cfg_we / cfg_index /
// cfg_data (index 0 is class_count, index 1+j is the center of class j) and
// must only change while no voxel is in flight; centers are expected in
// ascending order.
module partial_volume_membership import pvm_pkg::*; #(
	parameter int MAX_CLASSES    = PVM_MAX_CLASSES,
	parameter int INTENSITY_BITS = PVM_INTENSITY_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [CENTER_W-1:0]  voxel_intensity,
	input  wire logic                 last_voxel,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CENTER_W-1:0]  cfg_data,
	output logic                      done,
	output logic      [CLASS_W-1:0]   lower_class,
	output logic      [QW-1:0]        lower_weight,
	output logic      [QW-1:0]        upper_weight,
	output logic                      last_voxel_out
);

	// bits of the intensity and of the centers that take part
	localparam int XW  = (INTENSITY_BITS < CENTER_W) ? INTENSITY_BITS : CENTER_W;
	localparam int LAT = QW + 3;

	// fully pipelined, never refuses a transaction
	assign busy = 1'b0;

	// per-cell links of the division chain
	pvm_ctl_t      ctl_chain [QW+1];
	logic [XW-1:0] rem_chain [QW+1];
	logic [XW-1:0] div_chain [QW+1];
	logic [QW-1:0] quo_chain [QW+1];

	// classification front end, also holds the configuration registers
	pvm_classify #(
		.MAX_CLASSES (MAX_CLASSES),
		.XW          (XW)
	) u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (start),
		.x_i       (voxel_intensity[XW-1:0]),
		.last_i    (last_voxel),
		.ctl_o     (ctl_chain[0]),
		.num_o     (rem_chain[0]),
		.div_o     (div_chain[0])
	);

	assign quo_chain[0] = '0;

	// chain of division cells, msb of the quotient first; the first cell
	// only checks for a full weight since the numerator never exceeds the
	// divisor
	for (genvar g = 0; g < QW; g++) begin : g_cell
		pvm_div_cell #(
			.XW    (XW),
			.FIRST (g == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_chain[g]),
			.rem_i  (rem_chain[g]),
			.div_i  (div_chain[g]),
			.quo_i  (quo_chain[g]),
			.ctl_o  (ctl_chain[g+1]),
			.rem_o  (rem_chain[g+1]),
			.div_o  (div_chain[g+1]),
			.quo_o  (quo_chain[g+1])
		);
	end

	// result forming
	pvm_ctl_t      ctl_end;
	logic [QW-1:0] quo_end;
	logic [QW-1:0] wl;
	logic [QW-1:0] wu;

	assign ctl_end = ctl_chain[QW];
	assign quo_end = quo_chain[QW];

	always_comb begin
		unique case (ctl_end.mode)
			PVM_FULL_LOW: begin
				wl = Q_ONE;
				wu = '0;
			end
			PVM_FULL_UP: begin
				wl = '0;
				wu = Q_ONE;
			end
			PVM_DIVIDE: begin
				wl = Q_ONE - quo_end;
				wu = quo_end;
			end
			default: begin
				// no interval holds the sample (unordered centers)
				wl = '0;
				wu = '0;
			end
		endcase
	end

	logic               done_q;
	logic [CLASS_W-1:0] lower_q;
	logic [QW-1:0]      wl_q;
	logic [QW-1:0]      wu_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		lower_q <= ctl_end.lower;
		wl_q    <= wl;
		wu_q    <= wu;
		last_q  <= ctl_end.last;
	end

	assign done           = done_q;
	assign lower_class    = lower_q;
	assign lower_weight   = wl_q;
	assign upper_weight   = wu_q;
	assign last_voxel_out = last_q;

	// every accepted transaction comes out at the end of the pipeline
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing for an accepted transaction");

	// no result without a transaction issued at the matching time
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching transaction");

	// weights split one, or are both zero for unordered centers
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (({1'b0, lower_weight} + {1'b0, upper_weight}) == {1'b0, Q_ONE})
		|| (lower_weight == '0 && upper_weight == '0))
		else $error("membership weights do not sum to one");

	// the pair never reaches beyond the last class that MAX_CLASSES allows
	a_lower_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (lower_class == '0) || (lower_class < CLASS_W'(MAX_CLASSES - 1)))
		else $error("lower class out of range");

endmodule

`default_nettype wire

// ===== sv/pvm_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pvm_classify import pvm_pkg::*; #(
	parameter int MAX_CLASSES = PVM_MAX_CLASSES,
	parameter int XW          = CENTER_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CENTER_W-1:0]  cfg_data,
	input  wire logic                 in_valid,
	input  wire logic [XW-1:0]        x_i,
	input  wire logic                 last_i,
	output pvm_ctl_t                  ctl_o,
	output logic      [XW-1:0]        num_o,
	output logic      [XW-1:0]        div_o
);

	logic [COUNT_W-1:0]  class_count_q;
	logic [CENTER_W-1:0] center_q [MAX_CLASSES];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= COUNT_W'(3);
			for (int j = 0; j < MAX_CLASSES; j++) begin
				center_q[j] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_CLASS_COUNT) begin
				class_count_q <= cfg_data[COUNT_W-1:0];
			end
			for (int j = 0; j < MAX_CLASSES; j++) begin
				if (cfg_index == CFG_IDX_W'(CFG_CENTER_BASE + j)) begin
					center_q[j] <= cfg_data;
				end
			end
		end
	end

	// first stage: compare the sample against every centre
	logic                   valid_s1;
	logic [XW-1:0]          x_s1;
	logic                   last_s1;
	logic [MAX_CLASSES-1:0] ge_s1;
	logic [MAX_CLASSES-1:0] le_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_i;
		last_s1 <= last_i;
		for (int j = 0; j < MAX_CLASSES; j++) begin
			ge_s1[j] <= x_i >= center_q[j][XW-1:0];
			le_s1[j] <= x_i <= center_q[j][XW-1:0];
		end
	end

	// second stage: pick the interval and form the divider operands
	logic [COUNT_W-1:0] n_eff;
	logic               ge_last;
	logic               hit;
	logic [CLASS_W-1:0] sel;
	pvm_mode_t          mode;
	logic [CLASS_W-1:0] lower;
	logic [XW-1:0]      lo_c;
	logic [XW-1:0]      hi_c;

	always_comb begin
		if (class_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (class_count_q > COUNT_W'(MAX_CLASSES)) begin
			n_eff = COUNT_W'(MAX_CLASSES);
		end else begin
			n_eff = class_count_q;
		end

		ge_last = 1'b0;
		for (int j = 0; j < MAX_CLASSES; j++) begin
			if (COUNT_W'(j) == n_eff - COUNT_W'(1)) begin
				ge_last = ge_s1[j];
			end
		end

		// walk downward so the lowest matching interval wins
		hit = 1'b0;
		sel = '0;
		for (int k = MAX_CLASSES - 1; k >= 1; k--) begin
			if (COUNT_W'(k) < n_eff && ge_s1[k-1] && le_s1[k]) begin
				hit = 1'b1;
				sel = CLASS_W'(k - 1);
			end
		end

		lo_c = '0;
		hi_c = '0;
		for (int j = 0; j < MAX_CLASSES; j++) begin
			if (CLASS_W'(j) == sel) begin
				lo_c = center_q[j][XW-1:0];
			end
			if (CLASS_W'(j) == sel + CLASS_W'(1)) begin
				hi_c = center_q[j][XW-1:0];
			end
		end

		priority if (le_s1[0]) begin
			mode  = PVM_FULL_LOW;
			lower = '0;
		end else if (ge_last) begin
			if (n_eff >= COUNT_W'(2)) begin
				mode  = PVM_FULL_UP;
				lower = CLASS_W'(n_eff - COUNT_W'(2));
			end else begin
				mode  = PVM_FULL_LOW;
				lower = '0;
			end
		end else if (hit) begin
			// zero-width interval gives the lower class everything
			mode  = (hi_c == lo_c) ? PVM_FULL_LOW : PVM_DIVIDE;
			lower = sel;
		end else begin
			mode  = PVM_NONE;
			lower = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o.valid <= valid_s1;
			ctl_o.mode  <= mode;
			ctl_o.lower <= lower;
			ctl_o.last  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_o <= x_s1 - lo_c;
		div_o <= hi_c - lo_c;
	end

endmodule

`default_nettype wire

// ===== sv/pvm_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pvm_div_cell import pvm_pkg::*; #(
	parameter int XW    = CENTER_W,
	parameter bit FIRST = 1'b0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pvm_ctl_t      ctl_i,
	input  wire logic [XW-1:0] rem_i,
	input  wire logic [XW-1:0] div_i,
	input  wire logic [QW-1:0] quo_i,
	output pvm_ctl_t           ctl_o,
	output logic      [XW-1:0] rem_o,
	output logic      [XW-1:0] div_o,
	output logic      [QW-1:0] quo_o
);

	logic [XW:0]   trial;
	logic [XW:0]   diff;
	logic          qbit;
	logic [XW-1:0] rem_next;

	// one restoring step: the remainder stays below the divisor
	always_comb begin
		trial    = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
		diff     = trial - {1'b0, div_i};
		qbit     = trial >= {1'b0, div_i};
		rem_next = qbit ? diff[XW-1:0] : trial[XW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o.valid <= ctl_i.valid;
			ctl_o.mode  <= ctl_i.mode;
			ctl_o.lower <= ctl_i.lower;
			ctl_o.last  <= ctl_i.last;
		end
	end

	always_ff @(posedge clk) begin
		rem_o <= rem_next;
		div_o <= div_i;
		quo_o <= {quo_i[QW-2:0], qbit};
	end

endmodule

`default_nettype wire
